// ===== sv/bpa_pkg.sv =====
// Package for the buddy page allocator: word types, command and status codes,
// controller states, datapath operations and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

  // Defaults for the top-level parameters
  localparam int TOP_ORDER_DEF  = 10;
  localparam int POOL_PAGES_DEF = 16384;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [13:0] page_index;
    logic [14:0] page_count;
    logic [3:0]  block_order;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] block_page;
    logic [14:0] total_free_pages;
  } out_word_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_NOP,
    S_INIT_CHK, S_INIT_CLR, S_INIT_PH, S_INIT_LOOP, S_INIT_NEXT,
    S_ALC_CHK, S_ALC_SRCH, S_ALC_SPLIT,
    S_FR_CHK, S_FR_RD, S_FR_LOOP, S_FR_BCHK, S_FR_MERGE,
    S_PUSH_RD, S_PUSH_WT, S_PUSH_WP,
    S_UL_RD, S_UL_LD, S_UL_V, S_UL_VW, S_UL_N, S_UL_NW, S_UL_P,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_ACCEPT, OP_NOP, OP_CLR,
    OP_INIT_CHK, OP_INIT_PH, OP_INIT_LOOP, OP_INIT_NEXT,
    OP_ALC_CHK, OP_ALC_SRCH, OP_ALC_SPLIT,
    OP_FR_CHK, OP_FR_RD, OP_FR_LOOP, OP_FR_BCHK, OP_FR_MERGE,
    OP_PUSH_RD, OP_PUSH_WT, OP_PUSH_WP,
    OP_UL_RD, OP_UL_LD, OP_UL_V, OP_UL_VW, OP_UL_N, OP_UL_NW, OP_UL_P,
    OP_DONE
  } op_t;

  // Controller to datapath
  typedef struct packed {
    op_t     op;
    logic    fin;  // latch result status this cycle
    status_t st;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic bad_init;
    logic bad_order;
    logic bad_free;
    logic clr_last;
    logic range_more;
    logic ph_last;
    logic head_nil;
    logic cur_top;
    logic cur_gt_want;
    logic tail_nil;
    logic v_nil;
    logic n_nil;
    logic rd_free;
    logic buddy_out;
    logic buddy_match;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/bpa_ctrl.sv =====
// Controller of the buddy page allocator: sequences init, alloc and free
// over the datapath's list and page-record operations. Uses bpa_pkg.
`timescale 1ns / 1ps

module bpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  bpa_pkg::cmd_t       in_command,
  input  bpa_pkg::dp_stat_t   stat,
  output bpa_pkg::ctrl_cmd_t  cmd,
  output logic                ready
);
  import bpa_pkg::*;

  state_t state, state_next;

  // State register; reset starts the record clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd.op  = OP_IDLE;
    cmd.fin = 1'b0;
    cmd.st  = ST_OK;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          case (in_command)
            CMD_INIT:  state_next = S_INIT_CHK;
            CMD_ALLOC: state_next = S_ALC_CHK;
            CMD_FREE:  state_next = S_FR_CHK;
            default:   state_next = S_NOP;
          endcase
        end
      end
      S_NOP: begin
        cmd.op = OP_NOP;
        cmd.fin = 1'b1;
        state_next = S_DONE;
      end
      // ---- init ----
      S_INIT_CHK: begin
        cmd.op = OP_INIT_CHK;
        if (stat.bad_init) begin
          cmd.fin = 1'b1;
          cmd.st = ST_BAD;
          state_next = S_DONE;
        end else begin
          state_next = S_INIT_CLR;
        end
      end
      S_INIT_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = S_INIT_PH;
      end
      S_INIT_PH: begin
        cmd.op = OP_INIT_PH;
        state_next = S_INIT_LOOP;
      end
      S_INIT_LOOP: begin
        cmd.op = OP_INIT_LOOP;
        if (stat.range_more) begin
          state_next = S_PUSH_RD;
        end else if (stat.ph_last) begin
          cmd.fin = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_INIT_PH;
        end
      end
      S_INIT_NEXT: begin
        cmd.op = OP_INIT_NEXT;
        state_next = S_INIT_LOOP;
      end
      // ---- alloc ----
      S_ALC_CHK: begin
        cmd.op = OP_ALC_CHK;
        if (stat.bad_order) begin
          cmd.fin = 1'b1;
          cmd.st = ST_BAD;
          state_next = S_DONE;
        end else begin
          state_next = S_ALC_SRCH;
        end
      end
      S_ALC_SRCH: begin
        cmd.op = OP_ALC_SRCH;
        if (!stat.head_nil) begin
          state_next = S_UL_RD;
        end else if (stat.cur_top) begin
          cmd.fin = 1'b1;
          cmd.st = ST_EMPTY;
          state_next = S_DONE;
        end
      end
      S_ALC_SPLIT: begin
        cmd.op = OP_ALC_SPLIT;
        if (stat.cur_gt_want) begin
          state_next = S_PUSH_RD;
        end else begin
          cmd.fin = 1'b1;
          state_next = S_DONE;
        end
      end
      // ---- free ----
      S_FR_CHK: begin
        cmd.op = OP_FR_CHK;
        if (stat.bad_free) begin
          cmd.fin = 1'b1;
          cmd.st = ST_BAD;
          state_next = S_DONE;
        end else begin
          state_next = S_FR_RD;
        end
      end
      S_FR_RD: begin
        cmd.op = OP_FR_RD;
        if (stat.rd_free) begin
          cmd.fin = 1'b1;
          cmd.st = ST_BAD;
          state_next = S_DONE;
        end else begin
          state_next = S_FR_LOOP;
        end
      end
      S_FR_LOOP: begin
        cmd.op = OP_FR_LOOP;
        if (stat.cur_top || stat.buddy_out) state_next = S_PUSH_RD;
        else state_next = S_FR_BCHK;
      end
      S_FR_BCHK: begin
        cmd.op = OP_FR_BCHK;
        if (stat.buddy_match) state_next = S_UL_RD;
        else state_next = S_PUSH_RD;
      end
      S_FR_MERGE: begin
        cmd.op = OP_FR_MERGE;
        state_next = S_FR_LOOP;
      end
      // ---- push at list tail ----
      S_PUSH_RD: begin
        cmd.op = OP_PUSH_RD;
        if (stat.tail_nil) state_next = S_PUSH_WP;
        else state_next = S_PUSH_WT;
      end
      S_PUSH_WT: begin
        cmd.op = OP_PUSH_WT;
        state_next = S_PUSH_WP;
      end
      S_PUSH_WP: begin
        cmd.op = OP_PUSH_WP;
        case (stat.cmd)
          CMD_INIT:  state_next = S_INIT_NEXT;
          CMD_ALLOC: state_next = S_ALC_SPLIT;
          default: begin
            cmd.fin = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      // ---- unlink from list ----
      S_UL_RD: begin
        cmd.op = OP_UL_RD;
        state_next = S_UL_LD;
      end
      S_UL_LD: begin
        cmd.op = OP_UL_LD;
        state_next = S_UL_V;
      end
      S_UL_V: begin
        cmd.op = OP_UL_V;
        if (stat.v_nil) state_next = S_UL_N;
        else state_next = S_UL_VW;
      end
      S_UL_VW: begin
        cmd.op = OP_UL_VW;
        state_next = S_UL_N;
      end
      S_UL_N: begin
        cmd.op = OP_UL_N;
        if (stat.n_nil) state_next = S_UL_P;
        else state_next = S_UL_NW;
      end
      S_UL_NW: begin
        cmd.op = OP_UL_NW;
        state_next = S_UL_P;
      end
      S_UL_P: begin
        cmd.op = OP_UL_P;
        if (stat.cmd == CMD_ALLOC) state_next = S_ALC_SPLIT;
        else state_next = S_FR_MERGE;
      end
      S_DONE: begin
        cmd.op = OP_DONE;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/bpa_dpath.sv =====
// Datapath of the buddy page allocator: page-record memory, per-order list
// heads and tails, free total, input and output registers. Uses bpa_pkg.
`timescale 1ns / 1ps

module bpa_dpath #(
  parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
  parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bpa_pkg::in_word_t   in_word,
  input  bpa_pkg::ctrl_cmd_t  cmd,
  output bpa_pkg::dp_stat_t   stat,
  input  logic                out_stall,
  output logic                out_valid,
  output bpa_pkg::out_word_t  out_word
);
  import bpa_pkg::*;

  localparam int NORD = TOP_ORDER + 1;
  localparam int CW   = $clog2(NORD);
  localparam int PW   = $clog2(POOL_PAGES);
  localparam int AW   = ((PW > 15) ? PW : 15) + 1;  // page arithmetic width
  localparam int TW   = $clog2(POOL_PAGES + 1);

  localparam logic [1:0] PH_TOP  = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  localparam logic [AW-1:0] BLK  = AW'(1) << TOP_ORDER;
  localparam logic [AW-1:0] POOL = AW'(POOL_PAGES);

  // Link: top bit marks an empty link
  typedef struct packed {
    logic          free;
    logic [3:0]    ord;
    logic [PW:0]   nxt;
    logic [PW:0]   prv;
  } rec_t;

  localparam logic [PW:0] NIL = {1'b1, {PW{1'b0}}};

  rec_t mem [POOL_PAGES];
  rec_t rdata;
  logic          rd_en, we;
  logic [PW-1:0] rd_addr, wr_addr;
  rec_t          wdata;

  logic [PW:0] heads [NORD];
  logic [PW:0] tails [NORD];

  cmd_t          cmd_r;
  logic [13:0]   idx_r;
  logic [14:0]   cnt_r;
  logic [3:0]    ord_r;
  logic [3:0]    cur;
  logic [AW-1:0] pg, limit, nb, ne, base, endp, pp, p;
  logic          fit;
  logic [1:0]    ph;
  logic [PW-1:0] clr;
  logic [PW:0]   n_r, v_r;
  logic [TW-1:0] total;
  status_t       res_st;
  logic [AW-1:0] res_page;

  logic [CW-1:0] ci;
  logic [PW:0]   head_c, tail_c;
  logic [AW-1:0] idx_w, end_w, size_o, size_c, buddy, nb_w, ne_w, amt;
  logic [AW:0]   tot_w, sum_w, sub_w;

  assign ci     = cur[CW-1:0];
  assign head_c = heads[ci];
  assign tail_c = tails[ci];
  assign idx_w  = AW'(idx_r);
  assign end_w  = idx_w + AW'(cnt_r);
  assign nb_w   = (idx_w + BLK - AW'(1)) & ~(BLK - AW'(1));
  assign ne_w   = end_w & ~(BLK - AW'(1));
  assign size_o = AW'(1) << ord_r;
  assign size_c = AW'(1) << cur;
  assign buddy  = pp ^ size_c;
  assign amt    = (cmd_r == CMD_FREE) ? size_o : size_c;
  assign tot_w  = (AW + 1)'(total);
  assign sum_w  = tot_w + {1'b0, amt};
  assign sub_w  = (tot_w > {1'b0, size_c}) ? (tot_w - {1'b0, size_c}) : '0;

  // Status to the controller
  always_comb begin
    stat.cmd         = cmd_r;
    stat.bad_init    = (end_w > POOL);
    stat.bad_order   = (ord_r > 4'(TOP_ORDER));
    stat.bad_free    = (ord_r > 4'(TOP_ORDER)) || ((idx_w & (size_o - AW'(1))) != '0) ||
                       ((idx_w + size_o) > POOL);
    stat.clr_last    = (clr == PW'(POOL_PAGES - 1));
    stat.range_more  = (pg < limit);
    stat.ph_last     = (ph == PH_TAIL);
    stat.head_nil    = head_c[PW];
    stat.cur_top     = (cur == 4'(TOP_ORDER));
    stat.cur_gt_want = (cur > ord_r);
    stat.tail_nil    = tail_c[PW];
    stat.v_nil       = v_r[PW];
    stat.n_nil       = n_r[PW];
    stat.rd_free     = rdata.free;
    stat.buddy_out   = (buddy >= POOL);
    stat.buddy_match = rdata.free && (rdata.ord == cur);
    stat.out_free    = !out_valid || !out_stall;
  end

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = p[PW-1:0];
    we      = 1'b0;
    wr_addr = p[PW-1:0];
    wdata   = '{free: 1'b0, ord: 4'd0, nxt: NIL, prv: NIL};
    case (cmd.op)
      OP_FR_CHK: begin
        rd_en = 1'b1;
        rd_addr = idx_w[PW-1:0];
      end
      OP_FR_LOOP: begin
        rd_en = 1'b1;
        rd_addr = buddy[PW-1:0];
      end
      OP_PUSH_RD: begin
        rd_en = 1'b1;
        rd_addr = tail_c[PW-1:0];
      end
      OP_UL_RD: begin
        rd_en = 1'b1;
        rd_addr = p[PW-1:0];
      end
      OP_UL_V: begin
        rd_en = 1'b1;
        rd_addr = v_r[PW-1:0];
      end
      OP_UL_N: begin
        rd_en = 1'b1;
        rd_addr = n_r[PW-1:0];
      end
      OP_CLR: begin
        we = 1'b1;
        wr_addr = clr;
      end
      OP_PUSH_WT: begin
        we = 1'b1;
        wr_addr = tail_c[PW-1:0];
        wdata = rdata;
        wdata.nxt = {1'b0, pp[PW-1:0]};
      end
      OP_PUSH_WP: begin
        we = 1'b1;
        wr_addr = pp[PW-1:0];
        wdata = '{free: 1'b1, ord: cur, nxt: NIL, prv: tail_c};
      end
      OP_UL_VW: begin
        we = 1'b1;
        wr_addr = v_r[PW-1:0];
        wdata = rdata;
        wdata.nxt = n_r;
      end
      OP_UL_NW: begin
        we = 1'b1;
        wr_addr = n_r[PW-1:0];
        wdata = rdata;
        wdata.prv = v_r;
      end
      OP_UL_P: begin
        we = 1'b1;
        wr_addr = p[PW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Page-record memory
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wdata;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // List heads and tails
  always_ff @(posedge clk) begin
    if (rst || (cmd.op == OP_INIT_CHK && !stat.bad_init)) begin
      for (int i = 0; i < NORD; i++) begin
        heads[i] <= NIL;
        tails[i] <= NIL;
      end
    end else begin
      case (cmd.op)
        OP_PUSH_WP: begin
          if (tail_c[PW]) heads[ci] <= {1'b0, pp[PW-1:0]};
          tails[ci] <= {1'b0, pp[PW-1:0]};
        end
        OP_UL_V: begin
          if (v_r[PW]) heads[ci] <= n_r;
        end
        OP_UL_N: begin
          if (n_r[PW]) tails[ci] <= v_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Control counters and free total
  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      total <= '0;
    end else begin
      case (cmd.op)
        OP_CLR: clr <= stat.clr_last ? '0 : clr + PW'(1);
        OP_INIT_CHK: begin
          if (!stat.bad_init) total <= '0;
        end
        OP_PUSH_WP: total <= (sum_w > (AW + 1)'(POOL_PAGES)) ? TW'(POOL_PAGES)
                                                             : sum_w[TW-1:0];
        OP_UL_P: begin
          if (cmd_r == CMD_ALLOC) total <= sub_w[TW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Operation registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        cmd_r <= cmd_t'(in_word.command);
        idx_r <= in_word.page_index;
        cnt_r <= in_word.page_count;
        ord_r <= in_word.block_order;
      end
      OP_INIT_CHK: begin
        base <= idx_w;
        endp <= end_w;
        nb   <= nb_w;
        ne   <= ne_w;
        fit  <= (nb_w < ne_w);
        ph   <= PH_TOP;
      end
      OP_INIT_PH: begin
        case (ph)
          PH_TOP: begin
            pg <= nb;
            limit <= fit ? ne : nb;
          end
          PH_HEAD: begin
            pg <= base;
            limit <= fit ? nb : endp;
          end
          default: begin
            pg <= ne;
            limit <= fit ? endp : ne;
          end
        endcase
      end
      OP_INIT_LOOP: begin
        if (pg < limit) begin
          cur <= (ph == PH_TOP) ? 4'(TOP_ORDER) : 4'd0;
          pp  <= pg;
        end else if (ph != PH_TAIL) begin
          ph <= ph + 2'd1;
        end
      end
      OP_INIT_NEXT: pg <= pg + ((ph == PH_TOP) ? BLK : AW'(1));
      OP_ALC_CHK: cur <= ord_r;
      OP_ALC_SRCH: begin
        if (!head_c[PW]) p <= AW'(head_c[PW-1:0]);
        else if (cur != 4'(TOP_ORDER)) cur <= cur + 4'd1;
      end
      OP_ALC_SPLIT: begin
        if (cur > ord_r) begin
          cur <= cur - 4'd1;
          pp  <= p + (AW'(1) << (cur - 4'd1));
        end
      end
      OP_FR_CHK: begin
        pp  <= idx_w;
        cur <= ord_r;
      end
      OP_FR_LOOP: p <= buddy;
      OP_FR_MERGE: begin
        pp  <= pp & ~size_c;
        cur <= cur + 4'd1;
      end
      OP_UL_LD: begin
        n_r <= rdata.nxt;
        v_r <= rdata.prv;
      end
      default: begin
      end
    endcase
    if (cmd.fin) begin
      res_st   <= cmd.st;
      res_page <= (cmd.st == ST_OK && cmd_r == CMD_ALLOC) ? p : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_DONE && stat.out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DONE && stat.out_free) begin
      out_word.status           <= res_st;
      out_word.block_page       <= res_page[13:0];
      out_word.total_free_pages <= tot_w[14:0];
    end
  end

endmodule

// ===== sv/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_dpath.
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Word
// in      | input     | in_valid/in_stall  | command, page_index, page_count, block_order
// out     | output    | out_valid/out_stall| status, block_page, total_free_pages
//
// One word at a time. Alloc: the order check, a search step per order, the unlink
// and a push per split. Free: the checks, per merge step a buddy check and an
// unlink, then the last buddy check and the final push. Init: clearing of every
// page record through the single memory write port, then a push per listed block.
// Reset starts a clearing pass over all POOL_PAGES records; in_stall is high meanwhile.
// A result waits in the output register under out_stall; the next word is
// taken while it waits.

module buddy_page_allocator #(
  parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
  parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpa_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bpa_pkg::out_word_t out_word
);
  import bpa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      ready;

  assign in_stall = !ready;

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (cmd_t'(in_word.command)),
    .stat       (stat),
    .cmd        (cmd),
    .ready      (ready)
  );

  bpa_dpath #(
    .TOP_ORDER  (TOP_ORDER),
    .POOL_PAGES (POOL_PAGES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // Clearing pass follows reset, so no word is taken right after it
  a_reset_clear: assert property (@(posedge clk) rst |=> in_stall)
    else $error("word accepted during clearing pass");

  // Failed operations report no page
  a_fail_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_OK |-> out_word.block_page == 14'd0)
    else $error("page reported on failed operation");

  // Free total never exceeds the pool
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_word.total_free_pages) <= POOL_PAGES)
    else $error("free total above pool size");
`endif

endmodule

// ===== tb/sv/buddy_page_allocator_tb.sv =====
// Self-checking testbench for the buddy page allocator: a behavioral allocator
// model predicts every result word, random idling on both sides.
// Depends on bpa_pkg and buddy_page_allocator.
`timescale 1ns / 1ps

module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int TOPO = TOP_ORDER_DEF;
  localparam int POOL = POOL_PAGES_DEF;
  localparam int unsigned NONE = 32'hFFFF_FFFF;

  // Page allocator predictor plus queue of expected result words
  class alloc_scoreboard;
    bit          pfree [POOL];
    int unsigned porder[POOL];
    int unsigned pnext [POOL];
    int unsigned pprev [POOL];
    int unsigned heads[TOPO+1];
    int unsigned tails[TOPO+1];
    int unsigned nblk [TOPO+1];
    int unsigned total;
    out_word_t   expected_q[$];
    int          mismatches;

    function void wipe();
      for (int i = 0; i < POOL; i++) begin
        pfree[i] = 0; porder[i] = 0; pnext[i] = NONE; pprev[i] = NONE;
      end
      for (int o = 0; o <= TOPO; o++) begin
        heads[o] = NONE; tails[o] = NONE; nblk[o] = 0;
      end
      total = 0;
    endfunction

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void credit_pages(int unsigned v);
      total += v;
      if (total > POOL) total = POOL;
    endfunction

    // Append block to the tail of its order's list
    function void list_block(int unsigned o, int unsigned p);
      pnext[p] = NONE;
      pprev[p] = tails[o];
      if (tails[o] == NONE) heads[o] = p;
      else pnext[tails[o]] = p;
      tails[o] = p;
      pfree[p] = 1;
      porder[p] = o;
      nblk[o]++;
    endfunction

    function void unlist_block(int unsigned o, int unsigned p);
      int unsigned n, v;
      n = pnext[p];
      v = pprev[p];
      if (v == NONE) heads[o] = n; else pnext[v] = n;
      if (n == NONE) tails[o] = v; else pprev[n] = v;
      pnext[p] = NONE; pprev[p] = NONE; pfree[p] = 0; porder[p] = 0;
      if (nblk[o] > 0) nblk[o]--;
    endfunction

    function status_t init_region(int unsigned base, int unsigned n);
      int unsigned fin, blk, nb, ne;
      fin = base + n;
      blk = 1 << TOPO;
      if (fin > POOL) return ST_BAD;
      wipe();
      nb = (base + blk - 1) & ~(blk - 1);
      ne = fin & ~(blk - 1);
      if (nb < ne) begin
        for (int unsigned p = nb; p < ne; p += blk) begin
          list_block(TOPO, p); credit_pages(blk);
        end
        for (int unsigned p = base; p < nb; p++) begin
          list_block(0, p); credit_pages(1);
        end
        for (int unsigned p = ne; p < fin; p++) begin
          list_block(0, p); credit_pages(1);
        end
      end else begin
        for (int unsigned p = base; p < fin; p++) begin
          list_block(0, p); credit_pages(1);
        end
      end
      return ST_OK;
    endfunction

    // Smallest fitting order, split down, upper halves go back on the lists
    function status_t take_block(int unsigned want, output int unsigned page);
      int unsigned cur, p;
      page = 0;
      if (want > TOPO) return ST_BAD;
      for (cur = want; cur <= TOPO; cur++)
        if (heads[cur] != NONE) break;
      if (cur > TOPO) return ST_EMPTY;
      p = heads[cur];
      unlist_block(cur, p);
      total = (total > (1 << cur)) ? total - (1 << cur) : 0;
      while (cur > want) begin
        cur--;
        list_block(cur, p + (1 << cur));
        credit_pages(1 << cur);
      end
      page = p;
      return ST_OK;
    endfunction

    function status_t give_block(int unsigned head, int unsigned o);
      int unsigned cur, bud;
      if (o > TOPO) return ST_BAD;
      if ((head & ((1 << o) - 1)) != 0) return ST_BAD;
      if (head + (1 << o) > POOL) return ST_BAD;
      if (pfree[head]) return ST_BAD;
      cur = o;
      while (cur < TOPO) begin
        bud = head ^ (1 << cur);
        if (bud >= POOL) break;
        if (!pfree[bud] || porder[bud] != cur) break;
        unlist_block(cur, bud);
        head &= ~(1 << cur);
        cur++;
      end
      list_block(cur, head);
      credit_pages(1 << o);
      return ST_OK;
    endfunction

    // Accepted input word: predict and queue its result
    function out_word_t note_input(in_word_t w);
      out_word_t   r;
      status_t     st;
      int unsigned page;
      page = 0;
      st = ST_OK;
      case (cmd_t'(w.command))
        CMD_INIT:  st = init_region(w.page_index, w.page_count);
        CMD_ALLOC: st = take_block(w.block_order, page);
        CMD_FREE:  st = give_block(w.page_index, w.block_order);
        default:   st = ST_OK;
      endcase
      if (st != ST_OK) page = 0;
      r.status = st;
      r.block_page = page[13:0];
      r.total_free_pages = total[14:0];
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.block_page !== e.block_page ||
          got.total_free_pages !== e.total_free_pages) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d page %0d/%0d total %0d/%0d (exp/got)",
                   e.status, got.status, e.block_page, got.block_page,
                   e.total_free_pages, got.total_free_pages);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk, rst, in_valid, in_stall, out_valid, out_stall;
  in_word_t  in_word;
  out_word_t out_word;

  alloc_scoreboard sb = new();
  bit calm;
  int stall_left;
  int unsigned live_page[$];
  int unsigned live_order[$];

  buddy_page_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[buddy_page_allocator] ERROR");
    $finish;
  end

  // Result side: check accepted words, then a random stall unless calm
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_word);
        stall_left = calm ? 0 : $urandom_range(0, 19);
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
    out_stall <= (stall_left > 0);
  end

  // Send one word, wait for acceptance, then an optional gap
  task automatic send(logic [1:0] c, int unsigned idx, int unsigned cnt,
                      int unsigned ord);
    in_word_t  w;
    out_word_t r;
    int        gap;
    w.command = c;
    w.page_index = idx[13:0];
    w.page_count = cnt[14:0];
    w.block_order = ord[3:0];
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = sb.note_input(w);
    if (c == CMD_ALLOC && r.status == ST_OK) begin
      live_page.push_back(r.block_page);
      live_order.push_back(ord);
    end
    if (c == CMD_INIT && r.status == ST_OK) begin
      live_page.delete();
      live_order.delete();
    end
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic free_live();
    int k;
    k = $urandom_range(0, live_page.size() - 1);
    send(CMD_FREE, live_page[k], $urandom_range(0, 32767), live_order[k]);
    live_page.delete(k);
    live_order.delete(k);
  endtask

  initial begin
    int r;
    int unsigned base;
    rst = 1;
    in_valid = 0;
    in_word = '0;
    calm = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: bad regions, unused command, empty pool, bad orders
    send(CMD_INIT, 16000, 1000, 0);
    send(CMD_INIT, 16383, 16384, 15);
    send(CMD_NONE, 16383, 32767, 15);
    send(CMD_ALLOC, 0, 0, 0);
    send(CMD_ALLOC, 0, 0, 15);
    send(CMD_FREE, 0, 0, 11);
    send(CMD_INIT, 0, 0, 0);
    // Region too small for an aligned block: all single pages
    send(CMD_INIT, 3, 40, 0);
    send(CMD_ALLOC, 0, 0, 0);
    send(CMD_ALLOC, 0, 0, 2);
    send(CMD_FREE, 3, 0, 0);
    // Whole pool, splits and merges back up
    send(CMD_INIT, 0, 16384, 0);
    send(CMD_ALLOC, 0, 0, 0);
    send(CMD_ALLOC, 0, 0, 3);
    send(CMD_ALLOC, 0, 0, 10);
    send(CMD_FREE, 1, 0, 1);      // misaligned
    send(CMD_FREE, 2048, 0, 0);   // already heads a free block
    send(CMD_FREE, 16383, 0, 0);
    while (live_page.size() > 0) free_live();
    // Aligned middle plus head and tail pages
    send(CMD_INIT, 1000, 3000, 0);
    send(CMD_ALLOC, 0, 0, 10);
    send(CMD_ALLOC, 0, 0, 0);

    // Random part: mostly alloc/free pairs, some noise, a few re-inits
    for (int i = 0; i < 450; i++) begin
      calm = ((i / 50) % 3) == 1;
      if (i == 200) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
      end
      if (i % 75 == 0) begin
        if ($urandom_range(0, 1)) begin
          base = $urandom_range(0, 15) * 1024;
          send(CMD_INIT, base, $urandom_range(1, 16384 - base), 0);
        end else begin
          base = $urandom_range(0, 16383);
          send(CMD_INIT, base, $urandom_range(0, 16384 - base), 0);
        end
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 85 && live_page.size() == 0)) begin
        send(CMD_ALLOC, $urandom_range(0, 16383), $urandom_range(0, 32767),
             ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) :
             ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10) : $urandom_range(0, 15));
      end else if (r < 85) begin
        free_live();
      end else if (r < 95) begin
        send(CMD_FREE, $urandom_range(0, 16383), $urandom_range(0, 32767),
             $urandom_range(0, 15));
      end else begin
        send(CMD_NONE, $urandom_range(0, 16383), $urandom_range(0, 32767),
             $urandom_range(0, 15));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[buddy_page_allocator] OK");
    else
      $display("[buddy_page_allocator] ERROR");
    $finish;
  end

endmodule
